/* rtl/kmer_oh_pkg.sv */
package kmer_oh_pkg;

  localparam int KMER_MAX_DEF = 9;
  localparam int ROW_W        = 36;
  localparam int BASE_W       = 3;
  localparam int CNT_W        = 6;
  localparam int KLEN_W       = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;

  localparam logic [KLEN_W-1:0]    KLEN_RST = 4'd9;
  localparam logic [BASE_W-1:0]    BASE_N   = 3'b111;
  localparam logic [CFG_IDX_W-1:0] REG_KLEN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERED = 1'b1;

  typedef struct packed {
    logic load;
    logic eval;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_sts_t;

  function automatic logic [3:0] code_to_oh(input logic [BASE_W-1:0] code);
    logic [3:0] oh;
    oh = 4'b0000;
    if (!code[2]) begin
      oh[code[1:0]] = 1'b1;
    end
    return oh;
  endfunction

endpackage

/* rtl/kmer_oh_ctrl.sv */
module kmer_oh_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  kmer_oh_pkg::dp_sts_t   sts,
  output kmer_oh_pkg::ctrl_cmd_t cmd
);
  import kmer_oh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.empty) begin
          state_nxt = ST_IDLE;
        end else begin
          out_valid = 1'b1;
          if (!out_stall) begin
            cmd.pop = 1'b1;
            if (sts.last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/kmer_oh_dp.sv */
module kmer_oh_dp #(
  parameter int MAX_KMER = kmer_oh_pkg::KMER_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kmer_oh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmer_oh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic signed [kmer_oh_pkg::BASE_W-1:0] in_base_code,
  input  logic [kmer_oh_pkg::CNT_W-1:0]       in_sample_count,
  input  logic                                in_first_of_read,
  input  kmer_oh_pkg::ctrl_cmd_t              cmd,
  output kmer_oh_pkg::dp_sts_t                sts,
  output logic [kmer_oh_pkg::ROW_W-1:0]       row,
  output logic                                last_row
);
  import kmer_oh_pkg::*;

  localparam int K_W   = $clog2(MAX_KMER + 1);
  localparam int IDX_W = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
  localparam int EXT_W = KLEN_W + 1;
  localparam int RW    = 4 * MAX_KMER;
  localparam int EW    = (RW > ROW_W) ? RW : ROW_W;
  localparam int SH_W  = K_W + 2;

  logic [BASE_W-1:0] window_r [MAX_KMER];
  logic [CNT_W-1:0]  queue_r  [MAX_KMER];
  logic [K_W-1:0]    fill_r;
  logic [KLEN_W-1:0] klen_r;
  logic              centered_r;
  logic [ROW_W-1:0]  row_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [EXT_W-1:0] klen_ext;
  logic [K_W-1:0]   k_eff;
  logic [K_W-1:0]   delay;
  logic [SH_W-1:0]  shift_amt;
  logic [RW-1:0]    r_vec;
  logic [EW-1:0]    r_ext;
  logic [EW-1:0]    r_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r     <= KLEN_RST;
      centered_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KLEN:     klen_r     <= cfg_wdata[KLEN_W-1:0];
        REG_CENTERED: centered_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_KMER; j++) begin
        window_r[j] <= BASE_N;
        queue_r[j]  <= '0;
      end
      fill_r <= '0;
    end else if (cmd.load) begin
      window_r[0] <= in_base_code;
      queue_r[0]  <= in_sample_count;
      for (int j = 1; j < MAX_KMER; j++) begin
        window_r[j] <= in_first_of_read ? BASE_N : window_r[j-1];
        queue_r[j]  <= in_first_of_read ? '0 : queue_r[j-1];
      end
      if (in_first_of_read) begin
        fill_r <= K_W'(1);
      end else if (fill_r < K_W'(MAX_KMER)) begin
        fill_r <= fill_r + K_W'(1);
      end
    end
  end

  // effective kmer length and queue delay
  always_comb begin
    klen_ext = {1'b0, klen_r};
    if (klen_ext == '0) begin
      k_eff = K_W'(1);
    end else if (klen_ext > EXT_W'(MAX_KMER)) begin
      k_eff = K_W'(MAX_KMER);
    end else begin
      k_eff = K_W'(klen_ext);
    end
    delay     = centered_r ? (k_eff - K_W'(1) - (k_eff >> 1)) : (k_eff - K_W'(1));
    shift_amt = SH_W'(K_W'(MAX_KMER) - k_eff) << 2;
  end

  // newest entry lands in the top slot, shift drops the oldest slots beyond the kmer length
  always_comb begin
    for (int j = 0; j < MAX_KMER; j++) begin
      r_vec[4*(MAX_KMER-1-j) +: 4] = code_to_oh(window_r[j]);
    end
    r_ext   = EW'(r_vec);
    r_shift = r_ext >> shift_amt;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      row_r <= r_shift[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.eval) begin
      cnt_r <= (fill_r > delay) ? queue_r[delay[IDX_W-1:0]] : '0;
    end else if (cmd.pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign sts.empty = (cnt_r == '0);
  assign sts.last  = (cnt_r == CNT_W'(1));
  assign row       = row_r;
  assign last_row  = sts.last;

endmodule

/* rtl/kmer_one_hot_row_encoder.sv */
// the first row appears in the emit state, after the load and eval states
// a new request is taken only in the idle state, after every row of the previous
//   position has left, so requests do not overlap; output stalls hold the emit state
// the emit sequencer handles one position at a time, rows leave one per cycle while out_stall is low
// reset: synchronous active low, window to N, count queue and fill cleared,
//   kmer length 9, centered 0
module kmer_one_hot_row_encoder #(
  parameter int MAX_KMER = kmer_oh_pkg::KMER_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kmer_oh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmer_oh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [kmer_oh_pkg::BASE_W-1:0] in_base_code,
  input  logic [kmer_oh_pkg::CNT_W-1:0]         in_sample_count,
  input  logic                                  in_first_of_read,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [kmer_oh_pkg::ROW_W-1:0]         out_onehot_row,
  output logic                                  out_last_row
);
  import kmer_oh_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  kmer_oh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kmer_oh_dp #(
    .MAX_KMER (MAX_KMER)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_base_code     (in_base_code),
    .in_sample_count  (in_sample_count),
    .in_first_of_read (in_first_of_read),
    .cmd              (cmd),
    .sts              (sts),
    .row              (out_onehot_row),
    .last_row         (out_last_row)
  );

endmodule

/* tb/kmer_one_hot_row_encoder_checker.sv */
module kmer_one_hot_row_encoder_checker #(
  parameter int MAX_KMER = kmer_oh_pkg::KMER_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [kmer_oh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmer_oh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [kmer_oh_pkg::BASE_W-1:0] in_base_code,
  input  logic [kmer_oh_pkg::CNT_W-1:0]         in_sample_count,
  input  logic                                  in_first_of_read,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [kmer_oh_pkg::ROW_W-1:0]         out_onehot_row,
  input  logic                                  out_last_row,
  output int                                    fail_count,
  output int                                    rows_pending,
  output int                                    rows_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import kmer_oh_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } kmer_row_t;

  logic [BASE_W-1:0] window_q [MAX_KMER];
  logic [CNT_W-1:0]  count_q [MAX_KMER];
  int                fill_q;
  logic [KLEN_W-1:0] klen_q;
  logic              centered_q;
  kmer_row_t         expected_rows [$];
  kmer_row_t         head_row;
  int                fails = 0;
  int                checked = 0;

  task automatic clear_window();
    for (int j = 0; j < MAX_KMER; j++) begin
      window_q[j] = BASE_N;
      count_q[j] = '0;
    end
    fill_q = 0;
  endtask

  function automatic int kmer_span(input logic [KLEN_W-1:0] klen);
    if (klen == 0) begin
      return 1;
    end
    if (klen > MAX_KMER) begin
      return MAX_KMER;
    end
    return int'(klen);
  endfunction

  // shift one base in, then emit the rows of the position at the window delay
  task automatic predict_rows(input logic [BASE_W-1:0] code, input logic [CNT_W-1:0] cnt,
                              input logic first);
    int k;
    int lag;
    int pos;
    logic [BASE_W-1:0] slot;
    logic [ROW_W-1:0] row;
    kmer_row_t item;
    if (first) begin
      clear_window();
    end
    for (int j = MAX_KMER - 1; j > 0; j--) begin
      window_q[j] = window_q[j-1];
      count_q[j] = count_q[j-1];
    end
    window_q[0] = code;
    count_q[0] = cnt;
    if (fill_q < MAX_KMER) begin
      fill_q++;
    end
    k = kmer_span(klen_q);
    lag = centered_q ? (k - 1 - k / 2) : (k - 1);
    if (fill_q > lag) begin
      row = '0;
      for (int i = 0; i < k; i++) begin
        slot = window_q[k-1-i];
        pos = 4 * i + int'(slot[1:0]);
        if (!slot[2] && pos < ROW_W) begin
          row[pos] = 1'b1;
        end
      end
      for (int i = 0; i < int'(count_q[lag]); i++) begin
        item.row = row;
        item.last = (i + 1 == int'(count_q[lag]));
        expected_rows.push_back(item);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
      klen_q = KLEN_RST;
      centered_q = 1'b0;
      expected_rows.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KLEN: klen_q = cfg_wdata[KLEN_W-1:0];
          REG_CENTERED: centered_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_rows(in_base_code, in_sample_count, in_first_of_read);
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          fails++;
          $display("%0t: unexpected row, expected none, got row %h last %b",
                   $time, out_onehot_row, out_last_row);
        end else begin
          head_row = expected_rows.pop_front();
          checked++;
          if (head_row.row !== out_onehot_row) begin
            fails++;
            $display("%0t: onehot_row mismatch, expected %h, got %h",
                     $time, head_row.row, out_onehot_row);
          end
          if (head_row.last !== out_last_row) begin
            fails++;
            $display("%0t: last_row mismatch, expected %b, got %b",
                     $time, head_row.last, out_last_row);
          end
        end
      end
    end
    fail_count <= fails;
    rows_pending <= expected_rows.size();
    rows_checked <= checked;
  end

endmodule

/* tb/kmer_one_hot_row_encoder_tb.sv */
module kmer_one_hot_row_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmer_oh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int ITEMS_PER_SET  = 10;

  localparam logic signed [BASE_W-1:0] CODE_A    = 3'sd0;
  localparam logic signed [BASE_W-1:0] CODE_C    = 3'sd1;
  localparam logic signed [BASE_W-1:0] CODE_G    = 3'sd2;
  localparam logic signed [BASE_W-1:0] CODE_T    = 3'sd3;
  localparam logic signed [BASE_W-1:0] CODE_BAD4 = -3'sd4;
  localparam logic signed [BASE_W-1:0] CODE_BAD3 = -3'sd3;
  localparam logic signed [BASE_W-1:0] CODE_BAD2 = -3'sd2;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [BASE_W-1:0] in_base_code = '0;
  logic [CNT_W-1:0]         in_sample_count = '0;
  logic                     in_first_of_read = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ROW_W-1:0]         out_onehot_row;
  logic                     out_last_row;

  int fail_count;
  int rows_pending;
  int rows_checked;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int bases_sent = 0;
  int cur_kmer = KMER_MAX_DEF;

  int klen_set [9] = '{1, 9, 0, 15, 3, 5, 1, 2, 7};
  bit cen_set  [9] = '{0, 1, 1, 0, 1, 0, 1, 0, 1};

  kmer_one_hot_row_encoder #(.MAX_KMER(KMER_MAX_DEF)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_code     (in_base_code),
    .in_sample_count  (in_sample_count),
    .in_first_of_read (in_first_of_read),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_onehot_row   (out_onehot_row),
    .out_last_row     (out_last_row)
  );

  kmer_one_hot_row_encoder_checker #(.MAX_KMER(KMER_MAX_DEF)) row_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_code     (in_base_code),
    .in_sample_count  (in_sample_count),
    .in_first_of_read (in_first_of_read),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_onehot_row   (out_onehot_row),
    .out_last_row     (out_last_row),
    .fail_count       (fail_count),
    .rows_pending     (rows_pending),
    .rows_checked     (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d rows still due",
               $time, quiet_cycles, rows_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_base(input logic signed [BASE_W-1:0] code, input int cnt,
                           input logic first);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_code <= code;
    in_sample_count <= cnt[CNT_W-1:0];
    in_first_of_read <= first;
    do @(posedge clk); while (in_stall);
    bases_sent++;
  endtask

  // hold off requests until every predicted row has left the block
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [KLEN_W-1:0] klen, input logic cen);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_KLEN;
    cfg_wdata <= klen;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CENTERED;
    cfg_wdata <= {(CFG_DATA_W-1)'($urandom_range(0, 7)), cen};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_kmer = (klen == 0) ? 1 : (klen > KMER_MAX_DEF) ? KMER_MAX_DEF : int'(klen);
  endtask

  function automatic logic signed [BASE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return BASE_W'($urandom_range(0, 3));
    end
    if (r < 85) begin
      return BASE_N;
    end
    return BASE_W'($urandom_range(4, 6));
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 0;
    end
    if (r < 65) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 8);
    end
    if (r < 96) begin
      return 63;
    end
    return $urandom_range(9, 62);
  endfunction

  // one read: random bases, usually followed by an N flush of zero counts
  task automatic random_read();
    int len;
    bit flush;
    len = $urandom_range(2, 10);
    flush = ($urandom_range(0, 4) != 0);
    for (int j = 0; j < len; j++) begin
      send_base(pick_code(), pick_count(),
                (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
    end
    if (flush) begin
      for (int j = 0; j < cur_kmer; j++) begin
        send_base(BASE_N, 0, 1'b0);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      wait_drained();
    end
  endtask

  initial begin
    int target;
    idle_pct = 37;
    stall_pct <= 68;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window, every base code, count extremes, then a flush
    send_base(CODE_A, 1, 1'b0);
    send_base(CODE_C, 63, 1'b0);
    send_base(CODE_G, 0, 1'b0);
    send_base(CODE_T, 2, 1'b0);
    send_base(BASE_N, 3, 1'b0);
    send_base(CODE_BAD4, 1, 1'b0);
    send_base(CODE_BAD3, 1, 1'b0);
    send_base(CODE_BAD2, 2, 1'b0);
    send_base(CODE_T, 1, 1'b0);
    for (int j = 0; j < KMER_MAX_DEF; j++) begin
      send_base(BASE_N, 0, 1'b0);
    end
    // new read without a flush, then another read drops it
    send_base(CODE_G, 5, 1'b1);
    send_base(CODE_A, 4, 1'b0);
    send_base(CODE_C, 2, 1'b0);
    send_base(BASE_N, 0, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 37;
          stall_pct <= 68;
        end
        1: begin
          idle_pct = 68;
          stall_pct <= 37;
        end
        default: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      for (int s = 3 * phase; s < 3 * phase + 3; s++) begin
        apply_setting(klen_set[s][KLEN_W-1:0], cen_set[s]);
        target = bases_sent + ITEMS_PER_SET;
        while (bases_sent < target) random_read();
      end
    end

    wait_drained();
    $display("sent %0d bases over 9 kmer settings and the reset setting", bases_sent);
    $display("checked %0d rows, %0d mismatches", rows_checked, fail_count);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kmer_oh_pkg.sv
rtl/kmer_oh_ctrl.sv
rtl/kmer_oh_dp.sv
rtl/kmer_one_hot_row_encoder.sv
tb/kmer_one_hot_row_encoder_checker.sv
tb/kmer_one_hot_row_encoder_tb.sv
